@@ rtl/mtwg_pkg.sv @@
package mtwg_pkg;

  // Sizes of the state memory.
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned IDX_W        = 10;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FIRST_NEXT = IDX_W'(1);
  localparam logic [IDX_W-1:0] FIRST_FAR  = IDX_W'(TWIST_OFFSET);

  // Recurrence, twist and tempering constants.
  localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TW_UPPER     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] TW_LOWER     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  // One write into the state memory.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

endpackage

@@ rtl/mtwg_ram.sv @@
module mtwg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/mtwg_seeder.sv @@
module mtwg_seeder import mtwg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] seed,
  output mem_wr_t           wr,
  output logic              done
);

  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] word;

  // Next seed word from the previous one: xor-shift, multiply, then add the position; word 0 is the seed.
  always_comb begin
    mixed = prev_r ^ (prev_r >> 30);
    if (cnt_r == '0) begin
      word = seed;
    end else begin
      word = WORD_W'(SEED_MULT * mixed) + {{(WORD_W-IDX_W){1'b0}}, cnt_r};
    end
  end

  // Sweep over every state word, one a cycle.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    done     = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      prev_nxt = word;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  assign wr.en   = busy_r;
  assign wr.addr = cnt_r;
  assign wr.data = word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

endmodule

@@ rtl/mtwg_twist.sv @@
module mtwg_twist import mtwg_pkg::*; (
  input  logic [WORD_W-1:0] cur_word,
  input  logic [WORD_W-1:0] next_word,
  input  logic [WORD_W-1:0] far_word,
  output logic [WORD_W-1:0] new_word,
  output logic [WORD_W-1:0] tempered
);

  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] t1, t2, t3;

  // Twist of a single state word.
  always_comb begin
    y        = (cur_word & TW_UPPER) | (next_word & TW_LOWER);
    new_word = far_word ^ (y >> 1) ^ (y[0] ? TW_MATRIX : '0);
  end

  // Tempering of the freshly twisted word.
  always_comb begin
    t1       = new_word ^ (new_word >> 11);
    t2       = t1 ^ ((t1 << 7) & TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

endmodule

@@ rtl/mt19937_word_generator.sv @@
// MT19937 word generator: each input item yields one tempered 32-bit word.
// The 624 state words sit in two identical memories, each with one read port,
// so that the two words a twist step needs next are fetched while the current
// item is served; the state is twisted one word per item, which gives one item
// per cycle in steady state while the output is not stalled. The first item
// after reset, and any item with reseed set, first seeds the state from the
// seed register: the seeder writes one word per cycle through the memory write
// port, and the reads for the item's word are issued alongside the last seeding
// write. Such an item holds the input while it is accepted, while all 624 state
// words are seeded and while its word is produced, which waits for room at the
// output. The seed register may be written at any time; it takes effect at the
// next seeding.
module mt19937_word_generator import mtwg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_reseed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_random_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WORD_W-1:0] cfg_seed_value
);

  typedef enum logic [2:0] {
    ST_READY = 3'b001,
    ST_SEED  = 3'b010,
    ST_GEN   = 3'b100
  } state_t;

  state_t            st_r, st_nxt;
  logic              seeded_r, seeded_nxt;
  logic [WORD_W-1:0] seed_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  ra_next_r, ra_next_nxt;
  logic [IDX_W-1:0]  ra_far_r, ra_far_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic              out_space;
  logic              in_fire;
  logic              need_seed;
  logic              seed_start;
  logic              produce;
  mem_wr_t           seed_wr;
  logic              seed_done;
  mem_wr_t           mem_wr;
  logic [WORD_W-1:0] rd_next;
  logic [WORD_W-1:0] rd_far;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] tempered;

  // Handshake decisions.
  assign out_space  = !out_valid_r || out_ready;
  assign in_ready   = (st_r == ST_READY) && out_space;
  assign in_fire    = in_valid && in_ready;
  assign need_seed  = in_reseed || !seeded_r;
  assign seed_start = in_fire && need_seed;
  assign produce    = (in_fire && !need_seed) || ((st_r == ST_GEN) && out_space);
  assign cfg_ready  = 1'b1;

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= DEFAULT_SEED;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_seed_value;
    end
  end

  mtwg_seeder u_seeder (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_start),
    .seed  (seed_r),
    .wr    (seed_wr),
    .done  (seed_done)
  );

  mtwg_twist u_twist (
    .cur_word  (cur_r),
    .next_word (rd_next),
    .far_word  (rd_far),
    .new_word  (new_word),
    .tempered  (tempered)
  );

  // Memory write: the twisted word of the item, otherwise the seeder.
  always_comb begin
    if (produce) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = idx_r;
      mem_wr.data = new_word;
    end else begin
      mem_wr = seed_wr;
    end
  end

  // Both copies take every write; each serves one of the two reads.
  mtwg_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_next (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.data),
    .rd_addr (ra_next_nxt),
    .rd_data (rd_next)
  );

  mtwg_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_far (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.data),
    .rd_addr (ra_far_nxt),
    .rd_data (rd_far)
  );

  // Index and read addresses; the reads for the next item are issued as
  // the current item is produced, so its data is ready in the next cycle.
  always_comb begin
    idx_nxt     = idx_r;
    ra_next_nxt = ra_next_r;
    ra_far_nxt  = ra_far_r;
    cur_nxt     = cur_r;
    if (seed_done) begin
      idx_nxt     = '0;
      ra_next_nxt = FIRST_NEXT;
      ra_far_nxt  = FIRST_FAR;
    end else if (produce) begin
      idx_nxt     = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      ra_next_nxt = (ra_next_r == LAST_IDX) ? '0 : ra_next_r + 1'b1;
      ra_far_nxt  = (ra_far_r == LAST_IDX) ? '0 : ra_far_r + 1'b1;
      cur_nxt     = rd_next;
    end
    if (seed_wr.en && (seed_wr.addr == '0)) begin
      cur_nxt = seed_wr.data;
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt     = st_r;
    seeded_nxt = seeded_r;
    unique case (st_r)
      ST_READY: begin
        if (seed_start) begin
          st_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        if (seed_done) begin
          st_nxt     = ST_GEN;
          seeded_nxt = 1'b1;
        end
      end
      ST_GEN: begin
        if (out_space) begin
          st_nxt = ST_READY;
        end
      end
      default: st_nxt = ST_READY;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = tempered;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_READY;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      ra_next_r   <= FIRST_NEXT;
      ra_far_r    <= FIRST_FAR;
    end else begin
      st_r        <= st_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      ra_next_r   <= ra_next_nxt;
      ra_far_r    <= ra_far_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

@@ rtl/mtwg_checker.sv @@
module mtwg_checker import mtwg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_reseed,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_random_word
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its word.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_random_word))
    else $error("result word changed while stalled");

  // An accepted item either shows its word at once or blocks the input.
  a_item_served: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid || !in_ready)
    else $error("accepted item neither answered nor blocking");

  // A reseed item starts the seeding sweep, which takes no further item.
  a_reseed_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_reseed |=> !in_ready ##1 !in_ready)
    else $error("item taken during seeding");

endmodule

bind mt19937_word_generator mtwg_checker u_mtwg_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned W = mtwg_pkg::WORD_W;

  // Generator constants, kept apart from the design's own copies.
  localparam int unsigned MT_N          = 624;
  localparam int unsigned MT_M          = 397;
  localparam logic [31:0] MAT_A         = 32'h9908_b0df;
  localparam logic [31:0] MASK_HI       = 32'h8000_0000;
  localparam logic [31:0] MASK_LO       = 32'h7fff_ffff;
  localparam logic [31:0] INIT_MULT     = 32'd1812433253;
  localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
  localparam logic [31:0] BOOT_SEED     = 32'd5489;

  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_PRINTED  = 40;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic         in_reseed = 1'b0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] out_random_word;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [W-1:0] cfg_seed_value = '0;

  mt19937_word_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_reseed       (in_reseed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_seed_value  (cfg_seed_value)
  );

  always #6 clk = ~clk;

  // Predictor state: a private copy of the generator and its seed register.
  logic [31:0] mt_words [0:MT_N-1];
  int unsigned mt_pos = MT_N;
  bit          mt_seeded = 1'b0;
  logic [31:0] seed_reg = BOOT_SEED;

  logic [31:0] expected_words [$];

  int error_count = 0;
  int items_sent = 0;
  int reseeds_sent = 0;
  int results_checked = 0;
  int seeds_written = 0;
  int input_stall_cycles = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  bit hold_request = 1'b0;

  // Fill the state words from a seed with the multiplicative recurrence.
  function automatic void mt_fill(input logic [31:0] seed);
    logic [31:0] prev;
    mt_words[0] = seed;
    for (int i = 1; i < MT_N; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(i);
    end
    mt_pos = MT_N;
    mt_seeded = 1'b1;
  endfunction

  // Regenerate all 624 words in place.
  function automatic void mt_regenerate();
    logic [31:0] y;
    logic [31:0] v;
    for (int k = 0; k < MT_N; k++) begin
      y = (mt_words[k] & MASK_HI) | (mt_words[(k + 1) % MT_N] & MASK_LO);
      v = mt_words[(k + MT_M) % MT_N] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MAT_A;
      end
      mt_words[k] = v;
    end
    mt_pos = 0;
  endfunction

  // Work out the tempered word that one item should return.
  function automatic logic [31:0] next_mt_word(input logic reseed);
    logic [31:0] y;
    if (reseed || !mt_seeded) begin
      mt_fill(seed_reg);
    end
    if (mt_pos >= MT_N) begin
      mt_regenerate();
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_MASK_B);
    y = y ^ ((y << 15) & TEMPER_MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s: got %08h, expected %08h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Offer one item, in bursts with random gaps between them when sender_gaps is set.
  task automatic send_request(input logic reseed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_reseed <= reseed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(next_mt_word(reseed));
    items_sent++;
    if (reseed) begin
      reseeds_sent++;
    end
  endtask

  // Stop offering items and let every outstanding word come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_seed_value <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seed_reg = value;
    seeds_written++;
  endtask

  // The first item seeds from the default seed; reseeding restarts the stream.
  task automatic test_default_seed();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    wait_for_results();
  endtask

  // Seeds at the extremes, and a write that must not touch the running state.
  task automatic test_seed_extremes();
    write_seed(32'h0000_0000);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_for_results();
    write_seed(32'hffff_ffff);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_for_results();
    write_seed(32'h8000_0000);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_for_results();
    write_seed(32'h0000_0001);
    send_request(1'b1);
    send_request(1'b0);
    wait_for_results();
  endtask

  // A run long enough to cross the regeneration point, with a long output stall.
  task automatic test_full_period();
    write_seed($urandom);
    sender_gaps = 1'b0;
    send_request(1'b1);
    for (int i = 0; i < 630; i++) begin
      if (i == 120) begin
        hold_request = 1'b1;
      end
      if (i == 260) begin
        sender_gaps = 1'b1;
      end
      send_request(1'b0);
    end
    wait_for_results();
  endtask

  // Random seeds with reseeds scattered at random word positions.
  task automatic test_random_reseeds();
    for (int round = 0; round < 3; round++) begin
      write_seed($urandom);
      for (int i = 0; i < 25; i++) begin
        send_request($urandom_range(0, 5) == 0);
      end
      wait_for_results();
    end
  endtask

  // Result sink: stalls in stretches of random mode, plus one long hold-off.
  initial begin : result_sink
    int stretch;
    int mode;
    stretch = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(1, 40);
          mode = $urandom_range(0, 3);
        end
        stretch--;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= $urandom_range(0, 1);
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Count input stalls and compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (rst_n) begin
      if (in_valid && !in_ready) begin
        input_stall_cycles++;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with no item outstanding", out_random_word, 32'h0);
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want) begin
            report_mismatch("random_word", out_random_word, want);
          end
          results_checked++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_default_seed();
    test_seed_extremes();
    test_full_period();
    test_random_reseeds();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d items (%0d reseeds) over %0d seed writes; %0d words checked.",
             items_sent, reseeds_sent, seeds_written, results_checked);
    $display("Input was held off for %0d cycles; %0d mismatches.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d words outstanding.", expected_words.size());
    $display("FAILURE");
    $finish;
  end

endmodule
